// File: src/hiotib_pkg.sv
// Package with the types and constants of the handheld I/O timer and interrupt block.
package hiotib_pkg;

    // Default depth of the byte register file.
    localparam int REG_DEPTH_DEF = 64;

    // Field widths of an item.
    localparam int ADDR_W  = 6;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 23;
    localparam int BANK_W  = 3;
    localparam int LOAD_W  = 9;

    // Item kinds carried in tuser.
    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_FRAME = 2'd3
    } mode_t;

    // Register offsets with special behavior.
    localparam logic [ADDR_W-1:0] ADDR_JOY       = 6'h20;
    localparam logic [ADDR_W-1:0] ADDR_PORT      = 6'h21;
    localparam logic [ADDR_W-1:0] ADDR_PORT_LOW  = 6'h22;
    localparam logic [ADDR_W-1:0] ADDR_TIMER     = 6'h23;
    localparam logic [ADDR_W-1:0] ADDR_TIMER_ACK = 6'h24;
    localparam logic [ADDR_W-1:0] ADDR_DMA_ACK   = 6'h25;
    localparam logic [ADDR_W-1:0] ADDR_CTRL      = 6'h26;
    localparam logic [ADDR_W-1:0] ADDR_STATUS    = 6'h27;

    // Bits of the control register.
    localparam int CTRL_NMI_BIT   = 0;
    localparam int CTRL_TIRQ_BIT  = 1;
    localparam int CTRL_DIRQ_BIT  = 2;
    localparam int CTRL_SLOW_BIT  = 4;
    localparam int CTRL_BANK_LSB  = 5;

    // Timer shift amounts: 256 ticks per unit, or 16384 in slow mode.
    localparam int FAST_SHIFT = 8;
    localparam int SLOW_SHIFT = 14;

    // A load value of zero counts as 256 units.
    localparam logic [LOAD_W-1:0] ZERO_LOAD = 9'h100;

endpackage

// File: src/handheld_io_timer_irq_block.sv
// Top level of the handheld I/O register block with its timer, flags and interrupt lines.
// Each item is registered in the input stage and then in the output stage.
// Throughput: one item per cycle while the output is not stalled; the register file
// read at acceptance and the single update stage that follows it set this figure.
// Reset clears the valid bits of the register file (unwritten entries read as zero),
// the control shadows, the timer, both flags and the valid state of both stages.
// The block is ready to accept items as soon as reset is released.
module handheld_io_timer_irq_block #(
    parameter int REG_DEPTH = hiotib_pkg::REG_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [5:0] reg_address, [13:6] write_byte, [21:14] joypad_bits, [22] dma_done_set
    input  logic [23:0] s_tdata,
    // [1:0] mode
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] read_byte, [8] irq_line, [9] nmi_pulse, [12:10] rom_bank
    output logic [15:0] m_tdata
);

    localparam int AW = $clog2(REG_DEPTH);
    localparam logic [8:0] DEPTH_LIM = 9'(REG_DEPTH);

    // Input stage.
    logic                                in_valid_reg;
    hiotib_pkg::mode_t                   in_mode_reg;
    logic [hiotib_pkg::ADDR_W-1:0]       in_addr_reg;
    logic [hiotib_pkg::BYTE_W-1:0]       in_wbyte_reg;
    logic [hiotib_pkg::BYTE_W-1:0]       in_joy_reg;
    logic                                in_dma_reg;
    logic [hiotib_pkg::BYTE_W-1:0]       in_rdata_reg;

    // Output stage.
    logic                                m_tvalid_reg;
    logic [15:0]                         m_tdata_reg;

    // Block state.
    logic [hiotib_pkg::BYTE_W-1:0]       mem [REG_DEPTH];
    logic [REG_DEPTH-1:0]                valid_reg;
    logic [hiotib_pkg::BYTE_W-1:0]       ctrl_reg, ctrl_next;
    logic [3:0]                          port_low_reg, port_low_next;
    logic [hiotib_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic                                running_reg, running_next;
    logic                                fired_reg, fired_next;
    logic                                dma_reg, dma_next;

    // Handshake and decode.
    logic                                accept;
    logic                                advance;
    logic [hiotib_pkg::ADDR_W-1:0]       s_addr;
    logic                                in_range;
    logic                                do_write;
    logic                                forward;
    logic [hiotib_pkg::BYTE_W-1:0]       read_byte;
    logic                                nmi;
    logic                                irq;
    logic                                dma_eff;
    logic [hiotib_pkg::LOAD_W-1:0]       load;

    assign advance  = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign s_addr   = s_tdata[5:0];

    assign in_range = 9'(in_addr_reg) < DEPTH_LIM;
    assign do_write = advance && (in_mode_reg == hiotib_pkg::MODE_WRITE) && in_range;
    // The item being accepted reads the entry that the item in the stage writes now.
    assign forward  = do_write && (in_addr_reg == s_addr);

    // Register file storage.
    always_ff @(posedge aclk) begin
        if (do_write) begin
            mem[AW'(in_addr_reg)] <= in_wbyte_reg;
        end
    end

    // Valid bits of the register file.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (do_write) begin
            valid_reg[AW'(in_addr_reg)] <= 1'b1;
        end
    end

    // Input stage control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input stage payload with the register file read.
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_mode_reg  <= hiotib_pkg::mode_t'(s_tuser);
            in_addr_reg  <= s_addr;
            in_wbyte_reg <= s_tdata[13:6];
            in_joy_reg   <= s_tdata[21:14];
            in_dma_reg   <= s_tdata[22];
            if (forward) begin
                in_rdata_reg <= in_wbyte_reg;
            end else if (valid_reg[AW'(s_addr)]) begin
                in_rdata_reg <= mem[AW'(s_addr)];
            end else begin
                in_rdata_reg <= '0;
            end
        end
    end

    // Item processing: the DMA set applies first, then the item's own action.
    always_comb begin
        ctrl_next     = ctrl_reg;
        port_low_next = port_low_reg;
        count_next    = count_reg;
        running_next  = running_reg;
        fired_next    = fired_reg;
        dma_eff       = dma_reg | in_dma_reg;
        dma_next      = dma_eff;
        read_byte     = '0;
        nmi           = 1'b0;
        load          = (in_wbyte_reg == '0) ? hiotib_pkg::ZERO_LOAD
                                             : hiotib_pkg::LOAD_W'(in_wbyte_reg);
        case (in_mode_reg)
            hiotib_pkg::MODE_TICK: begin
                if (running_reg) begin
                    if (count_reg <= hiotib_pkg::COUNT_W'(1)) begin
                        count_next   = '0;
                        running_next = 1'b0;
                        fired_next   = 1'b1;
                    end else begin
                        count_next = count_reg - hiotib_pkg::COUNT_W'(1);
                    end
                end
            end
            hiotib_pkg::MODE_READ: begin
                if (in_range) begin
                    read_byte = in_rdata_reg;
                    if (in_addr_reg == hiotib_pkg::ADDR_JOY) begin
                        read_byte = in_joy_reg;
                    end else if (in_addr_reg == hiotib_pkg::ADDR_PORT) begin
                        read_byte = {in_rdata_reg[7:4], port_low_reg};
                    end else if (in_addr_reg == hiotib_pkg::ADDR_STATUS) begin
                        read_byte = {in_rdata_reg[7:2], dma_eff, fired_reg};
                    end else if (in_addr_reg == hiotib_pkg::ADDR_TIMER_ACK) begin
                        fired_next = 1'b0;
                    end else if (in_addr_reg == hiotib_pkg::ADDR_DMA_ACK) begin
                        dma_next = 1'b0;
                    end
                end
            end
            hiotib_pkg::MODE_WRITE: begin
                if (in_range) begin
                    if (in_addr_reg == hiotib_pkg::ADDR_CTRL) begin
                        ctrl_next = in_wbyte_reg;
                    end
                    if (in_addr_reg == hiotib_pkg::ADDR_PORT_LOW) begin
                        port_low_next = in_wbyte_reg[3:0];
                    end
                    if (in_addr_reg == hiotib_pkg::ADDR_TIMER) begin
                        // The slow bit is sampled as it stands before this write.
                        if (ctrl_reg[hiotib_pkg::CTRL_SLOW_BIT]) begin
                            count_next = hiotib_pkg::COUNT_W'(
                                {load, {hiotib_pkg::SLOW_SHIFT{1'b0}}});
                        end else begin
                            count_next = hiotib_pkg::COUNT_W'(
                                {load, {hiotib_pkg::FAST_SHIFT{1'b0}}});
                        end
                        running_next = 1'b1;
                    end
                end
            end
            default: begin
                nmi = ctrl_reg[hiotib_pkg::CTRL_NMI_BIT];
            end
        endcase
        irq = (fired_next && ctrl_next[hiotib_pkg::CTRL_TIRQ_BIT])
           || (dma_next && ctrl_next[hiotib_pkg::CTRL_DIRQ_BIT]);
    end

    // Timer, flags and control shadows.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg     <= '0;
            port_low_reg <= '0;
            count_reg    <= '0;
            running_reg  <= 1'b0;
            fired_reg    <= 1'b0;
            dma_reg      <= 1'b0;
        end else if (advance) begin
            ctrl_reg     <= ctrl_next;
            port_low_reg <= port_low_next;
            count_reg    <= count_next;
            running_reg  <= running_next;
            fired_reg    <= fired_next;
            dma_reg      <= dma_next;
        end
    end

    // Output stage control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Output stage payload.
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= {3'b000,
                            ctrl_next[hiotib_pkg::CTRL_BANK_LSB +: hiotib_pkg::BANK_W],
                            nmi, irq, read_byte};
        end
    end

endmodule

// File: sim/tb_handheld_io_timer_irq_block.sv
// Testbench for the handheld I/O register block: directed and random items checked against a predictor.
`timescale 1ns / 100ps

module tb_handheld_io_timer_irq_block;

    localparam int DEPTH         = hiotib_pkg::REG_DEPTH_DEF;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_ITEMS  = 600;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int SETTLE_CYCLES = 10;

    // Input item without the mode, packed as on s_tdata (lowest field last here).
    typedef struct packed {
        logic        dma_done_set;
        logic [7:0]  joypad_bits;
        logic [7:0]  write_byte;
        logic [5:0]  reg_address;
    } io_item_t;

    // Result item as packed on m_tdata.
    typedef struct packed {
        logic [2:0]  pad;
        logic [2:0]  rom_bank;
        logic        nmi_pulse;
        logic        irq_line;
        logic [7:0]  read_byte;
    } io_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    // Predicted state of the block.
    logic [7:0]                     io_regs [DEPTH];
    logic [hiotib_pkg::COUNT_W-1:0] timer_left;
    logic                           timer_on;
    logic                           timer_fired;
    logic                           dma_flag;

    io_result_t expected_results [$];
    int  errors = 0;
    int  items_sent = 0;
    int  results_checked = 0;
    int  timer_expiries = 0;
    int  cycle_count = 0;
    bit  no_idle = 1'b0;
    int  hold_requests = 0;
    int  holds_served = 0;
    int  stall_left = 0;

    handheld_io_timer_irq_block #(
        .REG_DEPTH(DEPTH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock with a 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
            $display("handheld_io_timer_irq_block: mismatch");
            $finish;
        end
    end

    // Receiver: random short and long stalls, plus a long counted hold on request.
    always @(posedge aclk) begin
        if (hold_requests != holds_served) begin
            holds_served <= hold_requests;
            stall_left   <= LONG_HOLD - 1;
            m_tready     <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 99) < 20) begin
            m_tready <= 1'b0;
            if ($urandom_range(0, 99) < 10)
                stall_left <= $urandom_range(8, 40);
            else
                stall_left <= $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each accepted result item with the oldest prediction.
    always @(posedge aclk) begin : check_results
        io_result_t got;
        io_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = io_result_t'(m_tdata);
            results_checked++;
            if (expected_results.size() == 0) begin
                $display("%0t: result item %h arrived with none expected", $time, m_tdata);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.read_byte !== want.read_byte) begin
                    $display("%0t: read_byte expected %h actual %h",
                             $time, want.read_byte, got.read_byte);
                    errors++;
                end
                if (got.irq_line !== want.irq_line) begin
                    $display("%0t: irq_line expected %b actual %b",
                             $time, want.irq_line, got.irq_line);
                    errors++;
                end
                if (got.nmi_pulse !== want.nmi_pulse) begin
                    $display("%0t: nmi_pulse expected %b actual %b",
                             $time, want.nmi_pulse, got.nmi_pulse);
                    errors++;
                end
                if (got.rom_bank !== want.rom_bank) begin
                    $display("%0t: rom_bank expected %h actual %h",
                             $time, want.rom_bank, got.rom_bank);
                    errors++;
                end
            end
        end
    end

    // Stored byte, or zero beyond the store.
    function automatic logic [7:0] stored_byte(input logic [hiotib_pkg::ADDR_W-1:0] a);
        return (int'(a) < DEPTH) ? io_regs[a] : 8'h00;
    endfunction

    // Apply one item to the predicted state and work out its result item.
    task automatic predict_io(input hiotib_pkg::mode_t md, input io_item_t it,
                              output io_result_t res);
        logic [7:0]  rd;
        logic [7:0]  ctrl;
        logic [7:0]  low;
        logic [hiotib_pkg::LOAD_W-1:0] load;
        logic [31:0] span;
        logic        nmi;
        rd  = 8'h00;
        nmi = 1'b0;
        // The DMA flag is set before any clearing read of the same item.
        if (it.dma_done_set)
            dma_flag = 1'b1;
        case (md)
            hiotib_pkg::MODE_TICK: begin
                if (timer_on) begin
                    if (timer_left <= 1) begin
                        timer_left  = '0;
                        timer_on    = 1'b0;
                        timer_fired = 1'b1;
                        timer_expiries++;
                    end else begin
                        timer_left = timer_left - 1'b1;
                    end
                end
            end
            hiotib_pkg::MODE_READ: begin
                if (int'(it.reg_address) < DEPTH) begin
                    rd = io_regs[it.reg_address];
                    case (it.reg_address)
                        hiotib_pkg::ADDR_JOY:       rd = it.joypad_bits;
                        hiotib_pkg::ADDR_PORT: begin
                            low = stored_byte(hiotib_pkg::ADDR_PORT_LOW);
                            rd  = {rd[7:4], low[3:0]};
                        end
                        hiotib_pkg::ADDR_STATUS:    rd = {rd[7:2], dma_flag, timer_fired};
                        hiotib_pkg::ADDR_TIMER_ACK: timer_fired = 1'b0;
                        hiotib_pkg::ADDR_DMA_ACK:   dma_flag = 1'b0;
                        default: ;
                    endcase
                end
            end
            hiotib_pkg::MODE_WRITE: begin
                if (int'(it.reg_address) < DEPTH) begin
                    io_regs[it.reg_address] = it.write_byte;
                    // A timer write loads the count, slow or fast by the control register now.
                    if (it.reg_address == hiotib_pkg::ADDR_TIMER) begin
                        ctrl = stored_byte(hiotib_pkg::ADDR_CTRL);
                        load = (it.write_byte == 8'h00) ? hiotib_pkg::ZERO_LOAD
                                                        : hiotib_pkg::LOAD_W'(it.write_byte);
                        span = 32'(load) << (ctrl[hiotib_pkg::CTRL_SLOW_BIT]
                                             ? hiotib_pkg::SLOW_SHIFT
                                             : hiotib_pkg::FAST_SHIFT);
                        timer_left = span[hiotib_pkg::COUNT_W-1:0];
                        timer_on   = 1'b1;
                    end
                end
            end
            default: begin
                ctrl = stored_byte(hiotib_pkg::ADDR_CTRL);
                nmi  = ctrl[hiotib_pkg::CTRL_NMI_BIT];
            end
        endcase
        ctrl = stored_byte(hiotib_pkg::ADDR_CTRL);
        res.pad       = '0;
        res.read_byte = rd;
        res.nmi_pulse = nmi;
        res.irq_line  = (timer_fired & ctrl[hiotib_pkg::CTRL_TIRQ_BIT])
                      | (dma_flag & ctrl[hiotib_pkg::CTRL_DIRQ_BIT]);
        res.rom_bank  = ctrl[7:hiotib_pkg::CTRL_BANK_LSB];
    endtask

    // Sender gap: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offer one item, wait for its handshake and record its prediction.
    task automatic send_item(input hiotib_pkg::mode_t md, input logic [5:0] addr,
                             input logic [7:0] wb, input logic [7:0] joy, input logic dma);
        int         gap;
        io_item_t   it;
        io_result_t res;
        gap = pick_gap();
        it  = '{dma_done_set: dma, joypad_bits: joy, write_byte: wb, reg_address: addr};
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= md;
        s_tdata  <= {1'b0, it};
        do @(posedge aclk); while (!s_tready);
        predict_io(md, it, res);
        expected_results.push_back(res);
        items_sent++;
    endtask

    task automatic send_write(input logic [5:0] addr, input logic [7:0] wb);
        send_item(hiotib_pkg::MODE_WRITE, addr, wb, 8'($urandom), 1'b0);
    endtask

    task automatic send_read(input logic [5:0] addr);
        send_item(hiotib_pkg::MODE_READ, addr, 8'($urandom), 8'($urandom), 1'b0);
    endtask

    // CPU-cycle ticks with random content in the fields a tick ignores.
    task automatic run_ticks(input int n);
        repeat (n) send_item(hiotib_pkg::MODE_TICK, 6'($urandom), 8'($urandom),
                             8'($urandom), 1'b0);
    endtask

    // Stop offering items until every predicted result item has come back.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
    endtask

    // One random item; a tick-heavy item mostly avoids restarting the timer.
    task automatic send_random(input bit tick_heavy);
        hiotib_pkg::mode_t md;
        logic [5:0]        addr;
        int                r;
        r = $urandom_range(0, 99);
        if (r < (tick_heavy ? 85 : 40))
            md = hiotib_pkg::MODE_TICK;
        else if (r < (tick_heavy ? 92 : 60))
            md = hiotib_pkg::MODE_READ;
        else if (r < (tick_heavy ? 97 : 85))
            md = hiotib_pkg::MODE_WRITE;
        else
            md = hiotib_pkg::MODE_FRAME;
        if ($urandom_range(0, 1) != 0)
            addr = 6'(hiotib_pkg::ADDR_JOY + $urandom_range(0, 7));
        else
            addr = 6'($urandom_range(0, 63));
        if (tick_heavy && md == hiotib_pkg::MODE_WRITE && addr == hiotib_pkg::ADDR_TIMER
            && $urandom_range(0, 9) != 0)
            addr = hiotib_pkg::ADDR_PORT_LOW;
        send_item(md, addr, 8'($urandom), 8'($urandom), $urandom_range(0, 7) == 0);
    endtask

    // Plain storage at both ends of the address range and an unwritten entry.
    task automatic test_register_file();
        send_read(6'h10);
        send_write(6'h00, 8'hFF);
        send_read(6'h00);
        send_write(6'h3F, 8'hA5);
        send_read(6'h3F);
        send_write(6'h00, 8'h00);
        send_read(6'h00);
        // Sound registers and the rest of the file are only stored.
        send_write(6'h30, 8'h5A);
        send_read(6'h30);
    endtask

    // Joypad, merged port and status reads.
    task automatic test_special_reads();
        send_write(hiotib_pkg::ADDR_JOY, 8'h12);
        send_item(hiotib_pkg::MODE_READ, hiotib_pkg::ADDR_JOY, 8'h00, 8'h00, 1'b0);
        send_item(hiotib_pkg::MODE_READ, hiotib_pkg::ADDR_JOY, 8'hFF, 8'hFF, 1'b0);
        send_write(hiotib_pkg::ADDR_PORT, 8'hAB);
        send_write(hiotib_pkg::ADDR_PORT_LOW, 8'h5C);
        send_read(hiotib_pkg::ADDR_PORT);
        send_write(hiotib_pkg::ADDR_STATUS, 8'hFF);
        send_read(hiotib_pkg::ADDR_STATUS);
    endtask

    // DMA flag, interrupt enables, ROM bank and the frame NMI.
    task automatic test_flags_and_lines();
        send_write(hiotib_pkg::ADDR_CTRL, 8'hE6);
        send_item(hiotib_pkg::MODE_TICK, 6'h00, 8'h00, 8'h00, 1'b1);
        send_read(hiotib_pkg::ADDR_STATUS);
        send_item(hiotib_pkg::MODE_FRAME, 6'h3F, 8'hFF, 8'hFF, 1'b0);
        // DMA set and its clearing read in the same item leave the flag clear.
        send_item(hiotib_pkg::MODE_READ, hiotib_pkg::ADDR_DMA_ACK, 8'h00, 8'h00, 1'b1);
        send_read(hiotib_pkg::ADDR_STATUS);
        send_write(hiotib_pkg::ADDR_CTRL, 8'h01);
        send_item(hiotib_pkg::MODE_FRAME, 6'h00, 8'h00, 8'h00, 1'b0);
    endtask

    // Fast timer: exact expiry, non-tick items do not count, stop and acknowledge.
    task automatic test_timer_fast();
        send_write(hiotib_pkg::ADDR_CTRL, 8'h02);
        send_write(hiotib_pkg::ADDR_TIMER, 8'h01);
        run_ticks(200);
        send_read(hiotib_pkg::ADDR_STATUS);
        send_item(hiotib_pkg::MODE_FRAME, 6'h00, 8'h00, 8'h00, 1'b0);
        send_write(6'h31, 8'h77);
        run_ticks(55);
        send_read(hiotib_pkg::ADDR_STATUS);
        run_ticks(1);
        run_ticks(3);
        send_read(hiotib_pkg::ADDR_TIMER_ACK);
        run_ticks(2);
    endtask

    // Restart while running, a zero load that outlasts a unit load, then exact reload.
    task automatic test_timer_restart();
        send_write(hiotib_pkg::ADDR_TIMER, 8'hFF);
        run_ticks(40);
        send_write(hiotib_pkg::ADDR_TIMER, 8'h00);
        run_ticks(260);
        send_read(hiotib_pkg::ADDR_STATUS);
        send_write(hiotib_pkg::ADDR_TIMER, 8'h01);
        run_ticks(255);
        send_read(hiotib_pkg::ADDR_STATUS);
        run_ticks(1);
        send_read(hiotib_pkg::ADDR_TIMER_ACK);
    endtask

    // Slow mode is taken at the moment of the timer write, so it outlasts a fast count.
    task automatic test_timer_slow();
        send_write(hiotib_pkg::ADDR_CTRL, 8'h12);
        send_write(hiotib_pkg::ADDR_TIMER, 8'h01);
        send_write(hiotib_pkg::ADDR_CTRL, 8'h02);
        run_ticks(270);
        send_read(hiotib_pkg::ADDR_STATUS);
    endtask

    // Long receiver hold while the sender keeps offering, so the block stalls its input.
    task automatic test_backpressure();
        hold_requests <= hold_requests + 1;
        no_idle <= 1'b1;
        repeat (30) send_random(1'b0);
        no_idle <= 1'b0;
    endtask

    // Timer sessions with random content, mixed with blocks of noise.
    task automatic test_random();
        int         sent;
        int         n;
        logic [7:0] ctrl;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) != 0) begin
                ctrl = 8'($urandom);
                if ($urandom_range(0, 9) != 0)
                    ctrl[hiotib_pkg::CTRL_SLOW_BIT] = 1'b0;
                send_write(hiotib_pkg::ADDR_CTRL, ctrl);
                send_write(hiotib_pkg::ADDR_TIMER,
                           ($urandom_range(0, 3) == 0) ? 8'h02 : 8'h01);
                n = $urandom_range(300, 450);
                repeat (n) send_random(1'b1);
                sent += n + 2;
            end else begin
                repeat (40) send_random(1'b0);
                sent += 40;
            end
        end
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++)
            io_regs[i] = 8'h00;
        timer_left  = '0;
        timer_on    = 1'b0;
        timer_fired = 1'b0;
        dma_flag    = 1'b0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_register_file();
        test_special_reads();
        test_flags_and_lines();
        wait_results_drained();
        test_timer_fast();
        test_timer_restart();
        wait_results_drained();
        test_timer_slow();
        test_backpressure();
        wait_results_drained();
        test_random();

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d items and checked %0d result items; the timer ran out %0d times.",
                 items_sent, results_checked, timer_expiries);
        $display("Covered storage, side-effect reads, flags, NMI, timer modes and back-pressure.");
        if (errors == 0)
            $display("handheld_io_timer_irq_block: match");
        else
            $display("handheld_io_timer_irq_block: mismatch");
        $finish;
    end

endmodule
